FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Condition must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hdl/cln_pkg.sv
`default_nettype none

package cln_pkg;

	localparam int MAX_SHIFT_DEF = 31;
	localparam int SHIFT_W = 5;

	// Action codes.
	localparam logic [2:0] ACT_CHAR        = 3'd0;
	localparam logic [2:0] ACT_INIT        = 3'd1;
	localparam logic [2:0] ACT_CLEAR       = 3'd2;
	localparam logic [2:0] ACT_SET_CURSOR  = 3'd3;
	localparam logic [2:0] ACT_SHIFT_RIGHT = 3'd4;
	localparam logic [2:0] ACT_SHIFT_LEFT  = 3'd5;

	// Controller commands.
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_FUNC_2LINE  = 8'h28;
	localparam logic [7:0] CMD_DDRAM       = 8'h80;
	localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
	localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
	localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;

	localparam logic [14:0] POWER_UP_US   = 15'd20000;
	localparam logic [12:0] WAKE_FIRST_US = 13'd5000;
	localparam logic [12:0] WAKE_US       = 13'd1000;
	localparam logic [12:0] CLEAR_US      = 13'd3000;

	// Characters with special meaning in the text stream.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [3:0] INIT_LAST = 4'd9;

	typedef struct packed {
		logic [2:0]         action;
		logic [7:0]         char_code;
		logic               last_char;
		logic               row;
		logic [3:0]         col;
		logic [SHIFT_W-1:0] shift_steps;
	} in_item_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [14:0] wait_before_us;
		logic [12:0] wait_after_us;
		logic        end_of_run;
	} out_item_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic [14:0] lead;
		logic [12:0] after;
	} nib_t;

	typedef struct packed {
		logic load;
		logic advance;
	} ctl_cmd_t;

	typedef struct packed {
		logic plan_empty;
		logic last_nibble;
	} dp_status_t;

	// Power-up sequence: three wake-up nibbles and the four-bit mode nibble, then three command bytes.
	function automatic nib_t init_nibble(input logic [3:0] idx);
		nib_t n;
		n = '{rs: RS_CMD, nib: 4'h0, lead: 15'd0, after: 13'd0};
		case (idx)
			4'd0: begin
				n.nib = WAKE_NIBBLE;
				n.lead = POWER_UP_US;
				n.after = WAKE_FIRST_US;
			end
			4'd1, 4'd2: begin
				n.nib = WAKE_NIBBLE;
				n.after = WAKE_US;
			end
			4'd3: begin
				n.nib = FOUR_BIT_NIBBLE;
				n.after = WAKE_US;
			end
			4'd4: n.nib = CMD_DISPLAY_ON[7:4];
			4'd5: n.nib = CMD_DISPLAY_ON[3:0];
			4'd6: n.nib = CMD_CLEAR[7:4];
			4'd7: begin
				n.nib = CMD_CLEAR[3:0];
				n.after = CLEAR_US;
			end
			4'd8: n.nib = CMD_FUNC_2LINE[7:4];
			4'd9: begin
				n.nib = CMD_FUNC_2LINE[3:0];
				n.after = CLEAR_US;
			end
			default: n.nib = 4'h0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/cln_ctrl.sv
`default_nettype none

module cln_ctrl
	import cln_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic in_xact;
	logic out_xact;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_xact   = in_valid && in_ready;
	assign out_xact  = out_valid && out_ready;

	assign cmd.load    = in_xact;
	assign cmd.advance = out_xact && !status.last_nibble;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// An item that causes no transfer finishes in its accept cycle.
					if (in_xact && !status.plan_empty) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_xact && status.last_nibble) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cln_datapath.sv
`default_nettype none

module cln_datapath
	import cln_pkg::*;
#(
	parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_item,
	input  wire ctl_cmd_t cmd,
	output dp_status_t    status,
	output out_item_t     out_item
);

	localparam int NibMax = (2 * MAX_SHIFT > 10) ? 2 * MAX_SHIFT : 10;
	localparam int CntW = $clog2(NibMax);
	localparam logic [SHIFT_W-1:0] MaxShiftW = SHIFT_W'(MAX_SHIFT);

	// Plan of the current item.
	logic               init_q;
	logic               rs0_q;
	logic [7:0]         byte0_q;
	logic [12:0]        after0_q;
	logic               rs1_q;
	logic [7:0]         byte1_q;
	logic [CntW-1:0]    last_idx_q;
	logic [CntW-1:0]    cnt_q;
	logic               slash_q;

	// Plan decode.
	logic               is_digit;
	logic               consumed;
	logic               hold_slash;
	logic               main_valid;
	logic               pre_rs;
	logic [7:0]         pre_byte;
	logic [SHIFT_W-1:0] steps_sat;
	logic [SHIFT_W-1:0] nbytes;
	logic [CntW:0]      nib_total;
	logic               n_init;
	logic               n_rs0;
	logic [7:0]         n_byte0;
	logic [12:0]        n_after0;
	logic               n_rs1;
	logic [7:0]         n_byte1;
	logic               n_slash;
	logic               n_empty;

	always_comb begin
		is_digit   = (in_item.char_code == CHAR_ZERO) || (in_item.char_code == CHAR_ONE);
		consumed   = slash_q && is_digit;
		hold_slash = !consumed && (in_item.char_code == CHAR_SLASH) && !in_item.last_char;
		main_valid = !consumed && !hold_slash && (in_item.char_code != CHAR_NUL)
			&& (in_item.char_code != CHAR_CR) && (in_item.char_code != CHAR_LF);
		if (is_digit) begin
			pre_rs   = RS_CMD;
			pre_byte = CMD_DDRAM | {1'b0, in_item.char_code[0], 6'd0};
		end else begin
			pre_rs   = RS_DATA;
			pre_byte = CHAR_SLASH;
		end
		steps_sat = (in_item.shift_steps > MaxShiftW) ? MaxShiftW : in_item.shift_steps;

		n_init   = 1'b0;
		n_rs0    = RS_CMD;
		n_byte0  = 8'h00;
		n_after0 = 13'd0;
		n_rs1    = RS_DATA;
		n_byte1  = in_item.char_code;
		n_slash  = 1'b0;
		nbytes   = '0;
		n_empty  = 1'b0;

		case (in_item.action)
			ACT_CHAR: begin
				n_slash = hold_slash;
				nbytes  = SHIFT_W'(slash_q) + SHIFT_W'(main_valid);
				if (slash_q) begin
					n_rs0   = pre_rs;
					n_byte0 = pre_byte;
				end else begin
					n_rs0   = RS_DATA;
					n_byte0 = in_item.char_code;
				end
			end
			ACT_INIT: begin
				n_init = 1'b1;
			end
			ACT_CLEAR: begin
				nbytes   = SHIFT_W'(1);
				n_byte0  = CMD_CLEAR;
				n_after0 = CLEAR_US;
			end
			ACT_SET_CURSOR: begin
				nbytes  = SHIFT_W'(1);
				n_byte0 = CMD_DDRAM | {1'b0, in_item.row, 2'b00, in_item.col};
			end
			ACT_SHIFT_RIGHT, ACT_SHIFT_LEFT: begin
				// Every byte of a shift run is the same command.
				nbytes  = steps_sat;
				n_byte0 = (in_item.action == ACT_SHIFT_RIGHT) ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
				n_rs1   = RS_CMD;
				n_byte1 = n_byte0;
			end
			default: begin
				// Unknown actions leave the slash hold alone.
				n_slash = slash_q;
				n_empty = 1'b1;
			end
		endcase

		if (!n_init && (nbytes == '0)) begin
			n_empty = 1'b1;
		end
		nib_total = (CntW + 1)'(nbytes) << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slash_q <= 1'b0;
			cnt_q   <= '0;
		end else if (cmd.load) begin
			slash_q <= n_slash;
			cnt_q   <= '0;
		end else if (cmd.advance) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			init_q   <= n_init;
			rs0_q    <= n_rs0;
			byte0_q  <= n_byte0;
			after0_q <= n_after0;
			rs1_q    <= n_rs1;
			byte1_q  <= n_byte1;
			if (n_init) begin
				last_idx_q <= CntW'(INIT_LAST);
			end else begin
				last_idx_q <= CntW'(nib_total - 1'b1);
			end
		end
	end

	// Transfer generation.
	logic       first_byte;
	logic       low_half;
	logic       sel_rs;
	logic [7:0] sel_byte;
	logic       at_last;
	nib_t       rom_nib;

	always_comb begin
		first_byte = (cnt_q[CntW-1:1] == '0);
		low_half   = cnt_q[0];
		sel_rs     = first_byte ? rs0_q : rs1_q;
		sel_byte   = first_byte ? byte0_q : byte1_q;
		rom_nib    = init_nibble(cnt_q[3:0]);

		at_last = (cnt_q == last_idx_q);
		out_item.end_of_run = at_last;
		if (init_q) begin
			out_item.reg_select     = rom_nib.rs;
			out_item.nibble         = rom_nib.nib;
			out_item.wait_before_us = rom_nib.lead;
			out_item.wait_after_us  = rom_nib.after;
		end else begin
			out_item.reg_select     = sel_rs;
			out_item.nibble         = low_half ? sel_byte[3:0] : sel_byte[7:4];
			out_item.wait_before_us = 15'd0;
			out_item.wait_after_us  = (low_half && first_byte) ? after0_q : 13'd0;
		end
	end

	assign status = '{plan_empty: n_empty, last_nibble: at_last};

endmodule

`default_nettype wire

FILE: hdl/char_lcd_nibble_sequencer.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_item  (in_item_t)
// out     | out_valid / out_ready| out_item (out_item_t)
//
// An item is taken in while the block is idle, then its transfers go out one per cycle
// while out_ready is high; a shift run is capped at MAX_SHIFT bytes.
// The transfer counter in the datapath steps through them; the next item is taken once
// the last transfer of the previous one has gone out.
// Reset clears the controller state, the transfer counter and the held slash.
// A low out_ready holds the current transfer unchanged until it is taken.
`default_nettype none

`include "assert_macros.svh"

module char_lcd_nibble_sequencer
	import cln_pkg::*;
#(
	parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_item
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	cln_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cln_datapath #(
		.MAX_SHIFT (MAX_SHIFT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

	logic out_xact;
	logic lead_wait;
	logic wake_cmd;

	assign out_xact  = out_valid && out_ready;
	assign lead_wait = out_valid && (out_item.wait_before_us != 15'd0);
	assign wake_cmd  = (out_item.nibble == WAKE_NIBBLE) && (out_item.reg_select == RS_CMD);

	`ASSERT_NEVER(a_one_side, clk, arst_n, in_ready && out_valid)
	`ASSERT_NEXT(a_run_done, clk, arst_n, out_xact && out_item.end_of_run, in_ready)
	`ASSERT_NEXT(a_run_more, clk, arst_n, out_xact && !out_item.end_of_run, out_valid)
	`ASSERT_IMPLIES(a_power_up, clk, arst_n, lead_wait, wake_cmd)

endmodule

`default_nettype wire

FILE: sim/tb_char_lcd_nibble_sequencer.sv
module tb_char_lcd_nibble_sequencer;
	import cln_pkg::*;

	// Action codes the block does not define; they must be ignored.
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;

	out_item_t lcd_xfer_q[$];
	out_item_t expected_xfer;
	logic slash_held;
	int sender_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int cycle_count;

	char_lcd_nibble_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void push_nibble(input logic rs, input logic [3:0] nib,
			input logic [14:0] lead, input logic [12:0] after);
		out_item_t x;
		x.reg_select = rs;
		x.nibble = nib;
		x.wait_before_us = lead;
		x.wait_after_us = after;
		x.end_of_run = 1'b0;
		lcd_xfer_q.push_back(x);
	endfunction

	function automatic void push_byte(input logic rs, input logic [7:0] code,
			input logic [12:0] after);
		push_nibble(rs, code[7:4], 15'd0, 13'd0);
		push_nibble(rs, code[3:0], 15'd0, after);
	endfunction

	// Works out the bus transfers one accepted request causes.
	function automatic void predict_lcd_transfers(input in_item_t it);
		int start_size;
		int steps;
		logic consumed;
		start_size = lcd_xfer_q.size();
		consumed = 1'b0;
		case (it.action)
			ACT_CHAR: begin
				if (slash_held) begin
					slash_held = 1'b0;
					if (it.char_code == CHAR_ZERO || it.char_code == CHAR_ONE) begin
						push_byte(RS_CMD, CMD_DDRAM | {1'b0, it.char_code == CHAR_ONE, 6'd0},
							13'd0);
						consumed = 1'b1;
					end else begin
						push_byte(RS_DATA, CHAR_SLASH, 13'd0);
					end
				end
				if (!consumed) begin
					if (it.char_code == CHAR_SLASH && !it.last_char) begin
						slash_held = 1'b1;
					end else if (it.char_code != CHAR_NUL && it.char_code != CHAR_CR &&
							it.char_code != CHAR_LF) begin
						push_byte(RS_DATA, it.char_code, 13'd0);
					end
				end
			end
			ACT_INIT: begin
				slash_held = 1'b0;
				push_nibble(RS_CMD, WAKE_NIBBLE, POWER_UP_US, WAKE_FIRST_US);
				push_nibble(RS_CMD, WAKE_NIBBLE, 15'd0, WAKE_US);
				push_nibble(RS_CMD, WAKE_NIBBLE, 15'd0, WAKE_US);
				push_nibble(RS_CMD, FOUR_BIT_NIBBLE, 15'd0, WAKE_US);
				push_byte(RS_CMD, CMD_DISPLAY_ON, 13'd0);
				push_byte(RS_CMD, CMD_CLEAR, CLEAR_US);
				push_byte(RS_CMD, CMD_FUNC_2LINE, CLEAR_US);
			end
			ACT_CLEAR: begin
				slash_held = 1'b0;
				push_byte(RS_CMD, CMD_CLEAR, CLEAR_US);
			end
			ACT_SET_CURSOR: begin
				slash_held = 1'b0;
				push_byte(RS_CMD, CMD_DDRAM | {1'b0, it.row, 2'b00, it.col}, 13'd0);
			end
			ACT_SHIFT_RIGHT, ACT_SHIFT_LEFT: begin
				slash_held = 1'b0;
				steps = int'(it.shift_steps);
				if (steps > MAX_SHIFT_DEF)
					steps = MAX_SHIFT_DEF;
				for (int i = 0; i < steps; i++)
					push_byte(RS_CMD, (it.action == ACT_SHIFT_RIGHT) ? CMD_SHIFT_RIGHT :
						CMD_SHIFT_LEFT, 13'd0);
			end
			default: begin
			end
		endcase
		if (lcd_xfer_q.size() > start_size)
			lcd_xfer_q[lcd_xfer_q.size() - 1].end_of_run = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input out_item_t exp,
			input out_item_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s: expected rs=%0d nib=%h before=%0d after=%0d end=%0d,",
				$realtime, what, exp.reg_select, exp.nibble, exp.wait_before_us,
				exp.wait_after_us, exp.end_of_run);
			$display("    got rs=%0d nib=%h before=%0d after=%0d end=%0d",
				got.reg_select, got.nibble, got.wait_before_us, got.wait_after_us,
				got.end_of_run);
		end
	endtask

	// Requests are predicted before results are checked, both on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_lcd_transfers(in_item);
			if (out_valid && out_ready) begin
				if (lcd_xfer_q.size() == 0) begin
					report_mismatch("unexpected transfer", '0, out_item);
				end else begin
					expected_xfer = lcd_xfer_q.pop_front();
					if (expected_xfer.reg_select !== out_item.reg_select ||
							expected_xfer.nibble !== out_item.nibble ||
							expected_xfer.wait_before_us !== out_item.wait_before_us ||
							expected_xfer.wait_after_us !== out_item.wait_after_us ||
							expected_xfer.end_of_run !== out_item.end_of_run)
						report_mismatch("transfer mismatch", expected_xfer, out_item);
				end
			end
		end
	end

	function automatic in_item_t make_request(input logic [2:0] act, input logic [7:0] code,
			input logic last);
		in_item_t it;
		it.action = act;
		it.char_code = code;
		it.last_char = last;
		it.row = 1'($urandom_range(1));
		it.col = 4'($urandom_range(15));
		it.shift_steps = SHIFT_W'($urandom_range(31));
		return it;
	endfunction

	function automatic logic [7:0] random_text_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return CHAR_SLASH;
		else if (pick < 16)
			return CHAR_ZERO;
		else if (pick < 22)
			return CHAR_ONE;
		else if (pick < 26)
			return CHAR_CR;
		else if (pick < 29)
			return CHAR_LF;
		else if (pick < 31)
			return CHAR_NUL;
		else if (pick < 75)
			return 8'($urandom_range(8'h7E, 8'h20));
		return 8'($urandom_range(255));
	endfunction

	// Called and returns at a rising edge; valid stays high into the next request
	// unless a gap is inserted.
	task automatic send_request(input in_item_t it);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] code, input logic last);
		send_request(make_request(ACT_CHAR, code, last));
	endtask

	task automatic send_cmd(input logic [2:0] act, input logic r, input logic [3:0] c,
			input logic [4:0] steps);
		in_item_t it;
		it = make_request(act, 8'($urandom_range(255)), 1'($urandom_range(1)));
		it.row = r;
		it.col = c;
		it.shift_steps = steps;
		send_request(it);
	endtask

	task automatic test_drain_pause();
		in_valid <= 1'b0;
		@(posedge clk);
		while (lcd_xfer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_cmd(ACT_INIT, 1'b0, 4'd0, 5'd0);
		send_char(8'hFF, 1'b0);
		send_char(CHAR_NUL, 1'b0);
		send_char(CHAR_CR, 1'b0);
		send_char(CHAR_LF, 1'b0);
		// Slash and digit turn into cursor moves, also on the last character.
		send_char(CHAR_SLASH, 1'b0);
		send_char(CHAR_ZERO, 1'b0);
		send_char(CHAR_SLASH, 1'b0);
		send_char(CHAR_ONE, 1'b1);
		send_char(CHAR_SLASH, 1'b0);
		send_char("A", 1'b0);
		send_char(CHAR_SLASH, 1'b0);
		send_char(CHAR_SLASH, 1'b0);
		send_char("x", 1'b1);
		send_char(CHAR_SLASH, 1'b1);
		send_char(CHAR_SLASH, 1'b0);
		send_char(CHAR_NUL, 1'b0);
		send_char(CHAR_SLASH, 1'b0);
		send_char(CHAR_CR, 1'b0);
		// Reserved actions leave a held slash in place.
		send_char(CHAR_SLASH, 1'b0);
		send_cmd(ACT_RSVD6, 1'b1, 4'd15, 5'd31);
		send_cmd(ACT_RSVD7, 1'b0, 4'd0, 5'd0);
		send_char(CHAR_ZERO, 1'b0);
		send_char(CHAR_SLASH, 1'b0);
		send_cmd(ACT_CLEAR, 1'b0, 4'd0, 5'd0);
		send_char(CHAR_ZERO, 1'b1);
		send_cmd(ACT_SET_CURSOR, 1'b1, 4'd15, 5'd0);
		send_cmd(ACT_SET_CURSOR, 1'b0, 4'd0, 5'd31);
		send_cmd(ACT_SHIFT_RIGHT, 1'b0, 4'd0, 5'd31);
		send_cmd(ACT_SHIFT_LEFT, 1'b1, 4'd15, 5'd0);
		send_cmd(ACT_SHIFT_LEFT, 1'b0, 4'd7, 5'd1);
	endtask

	task automatic test_random_traffic(input int sender_pct, input int recv_pct,
			input int n_items);
		int sent;
		int len;
		int pick;
		logic [4:0] steps;
		sender_idle_pct = sender_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				len = $urandom_range(10, 1);
				for (int i = 0; i < len; i++)
					send_char(random_text_char(), i == len - 1);
				sent += len;
			end else if (pick < 63) begin
				send_cmd(ACT_INIT, 1'($urandom_range(1)), 4'($urandom_range(15)),
					5'($urandom_range(31)));
				sent++;
			end else if (pick < 70) begin
				send_cmd(ACT_CLEAR, 1'($urandom_range(1)), 4'($urandom_range(15)),
					5'($urandom_range(31)));
				sent++;
			end else if (pick < 80) begin
				send_cmd(ACT_SET_CURSOR, 1'($urandom_range(1)), 4'($urandom_range(15)),
					5'($urandom_range(31)));
				sent++;
			end else if (pick < 92) begin
				// Long shift runs are kept rare so the run stays short.
				steps = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 16)) :
					5'($urandom_range(7));
				send_cmd($urandom_range(1) ? ACT_SHIFT_RIGHT : ACT_SHIFT_LEFT,
					1'($urandom_range(1)), 4'($urandom_range(15)), steps);
				sent++;
			end else if (pick < 96) begin
				send_cmd($urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7, 1'($urandom_range(1)),
					4'($urandom_range(15)), 5'($urandom_range(31)));
				sent++;
			end else begin
				send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		slash_held = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		sender_idle_pct = 9;
		recv_idle_pct = 57;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_drain_pause();
		test_random_traffic(9, 57, 150);
		test_drain_pause();
		test_random_traffic(57, 9, 150);
		test_drain_pause();
		test_random_traffic(0, 0, 150);

		in_valid <= 1'b0;
		while (lcd_xfer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && lcd_xfer_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
